[rtl/core/arm_cp15_mpu_protection_unit_defines.svh]
// assertion macros for the cp15 protection unit checker
// no dependencies
`ifndef ARM_CP15_MPU_PROTECTION_UNIT_DEFINES_SVH
`define ARM_CP15_MPU_PROTECTION_UNIT_DEFINES_SVH
// implication checked every clock outside reset
`define CP15_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CP15_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/core/cp15_pkg.sv]
// shared types and constants for the cp15 protection unit
// no dependencies
`timescale 1ns / 1ps
package cp15_pkg;
   localparam int NumRegionsDefault = 8;
   localparam logic [31:0] IdCode = 32'h41059461;
   localparam logic [31:0] CacheType = 32'h0F0D2112;
   localparam logic [31:0] TcmSize = 32'h00140180;
   localparam logic [31:0] CtrlMask = 32'h000FF085;
   localparam logic [31:0] CtrlForce = 32'h00000078;
   localparam logic [31:0] DtcmMask = 32'h0FFFF000;
   localparam logic [4:0] SizeAll = 5'h1F;
   localparam logic [31:0] DenySet = 32'hFFFFFFFF;
   localparam logic [31:0] PermReset = 32'h22222222;
   localparam logic [31:0] CtrlReset = 32'h00012078;
   localparam logic [31:0] DtcmReset = 32'h0080000A;
   localparam logic [31:0] ItcmReset = 32'h0000000C;

   typedef enum logic [1:0] {
      OP_READ = 2'd0, OP_WRITE = 2'd1, OP_CHECK = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  crn;
      logic [3:0]  crm;
      logic [2:0]  opc_one;
      logic [2:0]  opc_two;
      logic [31:0] write_data;
      logic [31:0] check_address;
      logic [2:0]  access_kind;
      logic        user_mode;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        ok;
      logic        wait_irq;
   } rsp_type;
endpackage

[rtl/core/cp15_queue.sv]
// two-entry request queue between front and back
// depends on cp15_pkg
`timescale 1ns / 1ps
module cp15_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cp15_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cp15_pkg::req_type out_data
);
   import cp15_pkg::*;
   req_type    mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

[rtl/core/cp15_exec.sv]
// back end: register file, region tables, checks and result register
// depends on cp15_pkg
`timescale 1ns / 1ps
module cp15_exec #(
   parameter int NUM_REGIONS = cp15_pkg::NumRegionsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cp15_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cp15_pkg::rsp_type out_data
);
   import cp15_pkg::*;
   localparam int IdxW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   logic [31:0] ctrl_ff, dcfg_ff, icfg_ff, wbuf_ff, dperm_ff, iperm_ff;
   logic [31:0] dlock_ff, ilock_ff, dtcm_ff, itcm_ff;
   logic [31:0] region_ff [NUM_REGIONS];
   logic [31:0] mask_ff [6][NUM_REGIONS];
   logic [31:0] set_ff  [6][NUM_REGIONS];
   logic        dirty_ff;
   logic        vld_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        take, rd_ok, wr_ok, wfi, chk_ok, rec;
   logic [31:0] rd_val;
   logic        reg_hit;
   logic [2:0]  crm_idx;
   logic [2:0]  o1, o2;
   logic [3:0]  crm;

   // a protection write holds off the next request while the tables update
   assign in_ready  = (!vld_ff || out_ready) && !dirty_ff;
   assign out_valid = vld_ff;
   assign out_data  = rsp_ff;
   assign take = in_valid && in_ready;
   assign o1 = in_data.opc_one;
   assign o2 = in_data.opc_two;
   assign crm = in_data.crm;
   assign crm_idx = crm[2:0];
   assign reg_hit = {1'b0, crm} < 5'(NUM_REGIONS);

   always_comb begin
      rd_ok = 1'b0; rd_val = '0;
      case (in_data.crn)
         4'd0: begin
            rd_ok = o1 == 3'd0 && crm == 4'd0;
            rd_val = o2 == 3'd1 ? CacheType : o2 == 3'd2 ? TcmSize : IdCode;
         end
         4'd1: begin rd_ok = o1 == 0 && o2 == 0 && crm == 0; rd_val = ctrl_ff; end
         4'd2: begin
            rd_ok = o1 == 0 && crm == 0 && o2 <= 3'd1;
            rd_val = o2[0] ? icfg_ff : dcfg_ff;
         end
         4'd3: begin rd_ok = o1 == 0 && o2 == 0 && crm == 0; rd_val = wbuf_ff; end
         4'd5: begin
            rd_ok = o1 == 0 && crm == 0 && (o2 == 3'd2 || o2 == 3'd3);
            rd_val = o2 == 3'd2 ? dperm_ff : iperm_ff;
         end
         4'd6: begin
            rd_ok = o1 == 0 && o2 == 0 && reg_hit;
            rd_val = region_ff[crm_idx[IdxW-1:0]];
         end
         4'd9: begin
            rd_ok = o1 == 0 && crm <= 4'd1 && o2 <= 3'd1;
            rd_val = crm[0] ? (o2[0] ? itcm_ff : dtcm_ff) : (o2[0] ? ilock_ff : dlock_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_ok = 1'b0; wfi = 1'b0; rec = 1'b0;
      case (in_data.crn)
         4'd1: wr_ok = o1 == 0 && o2 == 0 && crm == 0;
         4'd2: wr_ok = o1 == 0 && crm == 0 && o2 <= 3'd1;
         4'd3: wr_ok = o1 == 0 && o2 == 0 && crm == 0;
         4'd5: begin wr_ok = o1 == 0 && crm == 0 && (o2 == 3'd2 || o2 == 3'd3); rec = 1'b1; end
         4'd6: begin wr_ok = o1 == 0 && o2 == 0 && reg_hit; rec = 1'b1; end
         4'd7: begin wr_ok = o1 == 0 && crm == 0 && o2 == 3'd4; wfi = wr_ok; end
         4'd9: wr_ok = o1 == 0 && crm <= 4'd1 && o2 <= 3'd1;
         default: ;
      endcase
   end

   always_comb begin
      chk_ok = !ctrl_ff[0];
      if (ctrl_ff[0] && in_data.access_kind <= 3'd5) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            if ((in_data.check_address & mask_ff[in_data.access_kind][r])
                == set_ff[in_data.access_kind][r]) chk_ok = 1'b1;
         end
      end
   end

   logic do_wr;
   assign do_wr = take && in_data.op == OP_WRITE && !in_data.user_mode && wr_ok;

   always_comb begin
      rsp_in = '0;
      case (in_data.op)
         OP_READ: if (!in_data.user_mode && rd_ok) begin
            rsp_in.ok = 1'b1; rsp_in.read_data = rd_val;
         end
         OP_WRITE: if (!in_data.user_mode && wr_ok) begin
            rsp_in.ok = 1'b1; rsp_in.wait_irq = wfi;
         end
         OP_CHECK: rsp_in.ok = chk_ok;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; dirty_ff <= 1'b0;
      end else begin
         if (take) vld_ff <= 1'b1;
         else if (out_ready) vld_ff <= 1'b0;
         dirty_ff <= do_wr && rec;
      end
      if (take) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CtrlReset; dcfg_ff <= '0; icfg_ff <= '0; wbuf_ff <= '0;
         dperm_ff <= PermReset; iperm_ff <= PermReset; dlock_ff <= '0;
         ilock_ff <= '0; dtcm_ff <= DtcmReset; itcm_ff <= ItcmReset;
         for (int r = 0; r < NUM_REGIONS; r++) region_ff[r] <= '0;
      end else if (do_wr) begin
         case (in_data.crn)
            4'd1: ctrl_ff <= (in_data.write_data & CtrlMask) | CtrlForce;
            4'd2: if (o2[0]) icfg_ff <= in_data.write_data; else dcfg_ff <= in_data.write_data;
            4'd3: wbuf_ff <= in_data.write_data;
            4'd5: if (o2 == 3'd2) dperm_ff <= in_data.write_data;
                  else iperm_ff <= in_data.write_data;
            4'd6: region_ff[crm_idx[IdxW-1:0]] <= in_data.write_data;
            4'd9: if (crm[0]) begin
                     if (o2[0]) itcm_ff <= in_data.write_data;
                     else dtcm_ff <= in_data.write_data & DtcmMask;
                  end else begin
                     if (o2[0]) ilock_ff <= in_data.write_data;
                     else dlock_ff <= in_data.write_data;
                  end
            default: ;
         endcase
      end
   end

   // table rebuild, in the cycle after the register update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++)
            for (int r = 0; r < NUM_REGIONS; r++) begin
               mask_ff[k][r] <= '0; set_ff[k][r] <= '0;
            end
      end else if (dirty_ff) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            logic [31:0] m, s, rg;
            logic [3:0]  dp, ip;
            logic [5:0]  allow;
            rg = region_ff[r];
            dp = dperm_ff[4*r +: 4];
            ip = iperm_ff[4*r +: 4];
            m = '0; s = DenySet;
            if (rg[0]) begin
               if (rg[5:1] == SizeAll) s = '0;
               else begin
                  m = ~((32'd2 << rg[5:1]) - 32'd1) & 32'hFFFFF000;
                  s = rg & m;
               end
            end
            case (dp)
               4'd1: allow[3:0] = 4'b1010;
               4'd2: allow[3:0] = 4'b1110;
               4'd3: allow[3:0] = 4'b1111;
               4'd5: allow[3:0] = 4'b1000;
               4'd6: allow[3:0] = 4'b1100;
               default: allow[3:0] = 4'b0000;
            endcase
            allow[4] = ip == 4'd2 || ip == 4'd3 || ip == 4'd6;
            allow[5] = allow[4] || ip == 4'd1;
            for (int k = 0; k < 6; k++) begin
               if (k < 4 || ip != 4'd5) begin
                  mask_ff[k][r] <= allow[k] ? m : '0;
                  set_ff[k][r]  <= allow[k] ? s : DenySet;
               end
            end
         end
      end
   end
endmodule

[rtl/core/arm_cp15_mpu_protection_unit.sv]
// top level of the cp15 register file and protection unit
// depends on cp15_pkg, cp15_queue, cp15_exec
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/ready    | cp15_pkg::req_type
//   rsp_    | out       | rsp_valid/ready    | cp15_pkg::rsp_type
//
// one item per cycle unless held: queue, then back end into its result register
// a write to crn 5 or 6 holds the back end while the tables rebuild
// reset is synchronous and active high; tables come up zero, allowing all accesses
// a stalled result holds the back end; the queue keeps taking transfers until full
`timescale 1ns / 1ps
module arm_cp15_mpu_protection_unit #(
   parameter int NUM_REGIONS = cp15_pkg::NumRegionsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cp15_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cp15_pkg::rsp_type rsp_data
);
   import cp15_pkg::*;
   req_type q_data;
   logic    q_valid, q_ready;

   // front queue decouples the request side from the back end
   cp15_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // back end executes in order and registers the result
   cp15_exec #(.NUM_REGIONS(NUM_REGIONS)) u_exec (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );
endmodule

[rtl/core/cp15_checker.sv]
// port-level checker for the cp15 protection unit, with its bind
// depends on cp15_pkg and the defines header
`timescale 1ns / 1ps
`include "arm_cp15_mpu_protection_unit_defines.svh"
module cp15_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cp15_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cp15_pkg::rsp_type rsp_data
);
   import cp15_pkg::*;
   `CP15_ASSERT_IMPL(a_rd_zero, clock, reset, rsp_valid && !rsp_data.ok, rsp_data.read_data == '0, "failed response carries data")
   `CP15_ASSERT_IMPL(a_wfi_ok, clock, reset, rsp_valid && rsp_data.wait_irq, rsp_data.ok, "wait request without ok")
   `CP15_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")
   `CP15_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")
endmodule

bind arm_cp15_mpu_protection_unit cp15_checker u_checker (.*);
